// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the checker files.
// Each use expects clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, inactive during reset
`define CHK_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, inactive during reset
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/pmsp_pkg.sv -----
package pmsp_pkg;

    // Generator constants
    localparam logic [14:0] PM_MULT = 15'd16807;
    localparam logic [31:0] PM_MOD  = 32'h7FFF_FFFF;
    localparam logic [23:0] Q24_MAX = 24'hFF_FFFE;

    // Request codes
    localparam logic REQ_DRAW = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic signed [31:0] new_seed;
    } req_item_t;

    typedef struct packed {
        logic               is_draw;
        logic [30:0]        raw_value;
        logic [23:0]        deviate_q24;
        logic signed [31:0] current_seed;
    } rsp_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT_MUL,
        ST_INIT_RED,
        ST_DRAW_MUL,
        ST_DRAW_RED,
        ST_TBL_READ,
        ST_TBL_WRITE,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_seed;
        logic init_start;
        logic mul;
        logic red_init;
        logic red_draw;
        logic idx_load;
        logic tbl_read;
        logic tbl_write;
        logic out_load;
        logic out_draw;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_init;
        logic init_last;
    } sts_t;

    // Fold a product modulo 2^31-1: high part adds onto low part, one correction
    function automatic logic [30:0] pm_reduce(input logic [46:0] p);
        logic [31:0] sum;
        sum = {1'b0, p[30:0]} + {16'b0, p[46:31]};
        if (sum >= PM_MOD)
            sum = sum - PM_MOD;
        return sum[30:0];
    endfunction

    // floor(v * 2^24 / (2^31-1)), clamped below one
    function automatic logic [23:0] q24_frac(input logic [30:0] v);
        logic [31:0] rem;
        logic [24:0] quo;
        rem = {1'b0, v[6:0], 24'b0} + {8'b0, v[30:7]};
        quo = {1'b0, v[30:7]} + ((rem >= PM_MOD) ? 25'd1 : 25'd0);
        if (quo > {1'b0, Q24_MAX})
            quo = {1'b0, Q24_MAX};
        return quo[23:0];
    endfunction

endpackage

// ----- rtl/core/pmsp_dpath.sv -----
module pmsp_dpath #(
    parameter int TABLE_DEPTH   = 32,
    parameter int WARMUP_ROUNDS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pmsp_pkg::cmd_t        cmd,
    input  logic signed [31:0]    new_seed,
    output pmsp_pkg::sts_t        sts,
    output pmsp_pkg::rsp_item_t   rsp
);
    import pmsp_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int TOTAL  = TABLE_DEPTH + WARMUP_ROUNDS;
    localparam int CNT_W  = $clog2(TOTAL);
    localparam logic [31:0] NDIV = 32'(1 + (2147483646 / TABLE_DEPTH));

    logic [31:0]       seed_reg, seed_next;
    logic [30:0]       last_pick_reg, last_pick_next;
    logic [46:0]       mul_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [30:0]       rd_reg;
    rsp_item_t         rsp_reg;

    logic [30:0]       tbl_mem [TABLE_DEPTH];
    logic              tbl_we;
    logic [IDX_W-1:0]  tbl_waddr;
    logic [30:0]       tbl_wdata;

    logic [30:0]       red;
    logic [31:0]       seed_mag;
    logic [IDX_W-1:0]  idx_calc;

    // Modular reduction of the registered product
    assign red = pm_reduce(mul_reg);

    // Starting value of an initialization: magnitude of a negative seed, else one
    assign seed_mag = seed_reg[31] ? (~seed_reg + 32'd1) : 32'd1;

    // Table index: highest bucket threshold reached by the last pick, top entry at most
    always_comb
    begin
        idx_calc = '0;
        for (int k = 1; k < TABLE_DEPTH; k++)
        begin
            if ({1'b0, last_pick_reg} >= NDIV * 32'(k))
                idx_calc = IDX_W'(k);
        end
    end

    // Next state of the datapath registers
    always_comb
    begin
        seed_next      = seed_reg;
        last_pick_next = last_pick_reg;
        cnt_next       = cnt_reg;
        tbl_we         = 1'b0;
        tbl_waddr      = idx_reg;
        tbl_wdata      = seed_reg[30:0];

        if (cmd.load_seed)
            seed_next = new_seed;
        if (cmd.init_start)
        begin
            seed_next = seed_mag;
            cnt_next  = CNT_W'(TOTAL - 1);
        end
        if (cmd.red_init)
        begin
            seed_next = {1'b0, red};
            if (cnt_reg != '0)
                cnt_next = cnt_reg - 1'b1;
            else
                last_pick_next = red;
            if ({1'b0, cnt_reg} < (CNT_W + 1)'(TABLE_DEPTH))
            begin
                tbl_we    = 1'b1;
                tbl_waddr = cnt_reg[IDX_W-1:0];
                tbl_wdata = red;
            end
        end
        if (cmd.red_draw)
            seed_next = {1'b0, red};
        if (cmd.tbl_write)
        begin
            tbl_we         = 1'b1;
            last_pick_next = rd_reg;
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= '0;
            last_pick_reg <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            seed_reg      <= seed_next;
            last_pick_reg <= last_pick_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.idx_load)
            idx_reg <= idx_calc;
        if (cmd.mul)
            mul_reg <= 47'(seed_reg) * 47'(PM_MULT);
        if (cmd.out_load)
        begin
            rsp_reg.is_draw      <= cmd.out_draw;
            rsp_reg.raw_value    <= cmd.out_draw ? last_pick_reg : 31'd0;
            rsp_reg.deviate_q24  <= cmd.out_draw ? q24_frac(last_pick_reg) : 24'd0;
            rsp_reg.current_seed <= seed_reg;
        end
    end

    // Shuffle table: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (tbl_we)
            tbl_mem[tbl_waddr] <= tbl_wdata;
        if (cmd.tbl_read)
            rd_reg <= tbl_mem[idx_reg];
    end

    assign sts.need_init = (seed_reg == 32'd0) || seed_reg[31] || (last_pick_reg == 31'd0);
    assign sts.init_last = (cnt_reg == '0);
    assign rsp           = rsp_reg;

endmodule

// ----- rtl/core/pmsp_ctrl.sv -----
module pmsp_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_type,
    output logic           req_stall,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    input  pmsp_pkg::sts_t sts,
    output pmsp_pkg::cmd_t cmd
);
    import pmsp_pkg::*;

    state_t state_reg, state_next;
    logic   draw_reg, draw_next;
    logic   rsp_valid_reg, rsp_valid_next;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        draw_next      = draw_reg;
        cmd            = '0;
        cmd.out_draw   = draw_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_type == REQ_LOAD)
                    begin
                        cmd.load_seed = 1'b1;
                        draw_next     = 1'b0;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        draw_next = 1'b1;
                        if (sts.need_init)
                        begin
                            cmd.init_start = 1'b1;
                            state_next     = ST_INIT_MUL;
                        end
                        else
                            state_next = ST_DRAW_MUL;
                    end
                end
            end
            ST_INIT_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_INIT_RED;
            end
            ST_INIT_RED:
            begin
                cmd.red_init = 1'b1;
                state_next   = sts.init_last ? ST_DRAW_MUL : ST_INIT_MUL;
            end
            ST_DRAW_MUL:
            begin
                cmd.mul      = 1'b1;
                cmd.idx_load = 1'b1;
                state_next   = ST_DRAW_RED;
            end
            ST_DRAW_RED:
            begin
                cmd.red_draw = 1'b1;
                state_next   = ST_TBL_READ;
            end
            ST_TBL_READ:
            begin
                cmd.tbl_read = 1'b1;
                state_next   = ST_TBL_WRITE;
            end
            ST_TBL_WRITE:
            begin
                cmd.tbl_write = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                // Hold until the result register is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Result valid: set on load, drop once taken
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.out_load)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            draw_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            draw_reg      <= draw_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

// ----- rtl/core/park_miller_shuffled_prng.sv -----
// Park-Miller minimal standard generator (x * 16807 mod 2^31-1) behind a
// Bays-Durham shuffle table, one item in and one result out at a time. A seed
// load goes from accept straight to the result register load. A draw steps
// through the shared multiply-and-fold unit that advances the seed (multiply,
// then fold), then reads the picked table entry, writes the new seed into it and
// loads the result register. The table index is found by comparing the last pick
// against fixed bucket thresholds and is latched during the multiply. A draw that
// must initialize first (seed not positive or table unfilled) first runs one
// multiply-and-fold round per table entry and warm-up round through that same
// unit. The result register lets a new item be accepted while a result waits;
// that item then holds in its last state until the waiting result is taken.
module park_miller_shuffled_prng #(
    parameter int TABLE_DEPTH   = 32,
    parameter int WARMUP_ROUNDS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  pmsp_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output pmsp_pkg::rsp_item_t rsp
);
    import pmsp_pkg::*;

    cmd_t cmd;
    sts_t sts;

    pmsp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_type  (req.req_type),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    pmsp_dpath #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .WARMUP_ROUNDS (WARMUP_ROUNDS)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .new_seed (req.new_seed),
        .sts      (sts),
        .rsp      (rsp)
    );

endmodule

// ----- rtl/core/pmsp_checker.sv -----
`include "assert_macros.svh"

module pmsp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_stall,
    input logic                rsp_valid,
    input logic                rsp_stall,
    input pmsp_pkg::rsp_item_t rsp
);
    import pmsp_pkg::*;

    // Hold a stalled result
    `CHK_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "result dropped while stalled")
    `CHK_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp), "result changed while stalled")

    // One item at a time: stall right after an accept
    `CHK_NEXT(a_one_item, req_valid && !req_stall, req_stall, "second item taken while busy")

    // A seed-load result carries no deviate
    `CHK_SAME(a_load_zero, rsp_valid && !rsp.is_draw,
              rsp.raw_value == 31'd0 && rsp.deviate_q24 == 24'd0, "seed load result not zero")

    // A draw stays below one and below the modulus
    `CHK_SAME(a_draw_range, rsp_valid && rsp.is_draw,
              rsp.deviate_q24 <= Q24_MAX && rsp.raw_value != 31'h7FFF_FFFF,
              "draw out of range")

endmodule

bind park_miller_shuffled_prng pmsp_checker u_pmsp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
